// File: rtl/core/lsb_first_frame_field_unpacker_assert.svh
// Assertion macros for the frame field unpacker.
`ifndef LSB_FIRST_FRAME_FIELD_UNPACKER_ASSERT_SVH
`define LSB_FIRST_FRAME_FIELD_UNPACKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LFFU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lffu assertion failed");
`define LFFU_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lffu forbidden condition");
`else
`define LFFU_ASSERT(label, clk, rst, prop)
`define LFFU_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// File: rtl/core/lffu_pkg.sv
// Shared types and constants for the frame field unpacker.
package lffu_pkg;

   localparam int WIDE_CHANNELS_DEFAULT = 8;
   localparam int NARROW_COUNT_DEFAULT  = 8;

   localparam logic [4:0] WIDE_BITS   = 5'd20;
   localparam logic [4:0] NARROW_BITS = 5'd16;
   localparam logic [4:0] BYTE_BITS   = 5'd8;
   localparam int         WIDE_SHIFT  = 12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [31:0] field_value;
      logic [3:0]         channel_index;
      logic               is_wide;
      logic               frame_end;
      logic               truncated;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      result_type first;
      logic       second_valid;
      result_type second;
   } result_pair_type;

endpackage

// File: rtl/core/lffu_core.sv
// Bit buffer, field extraction and frame sequencing for one beat per cycle while fire is high.
module lffu_core #(
   parameter int WIDE_CHANNELS = lffu_pkg::WIDE_CHANNELS_DEFAULT,
   parameter int NARROW_COUNT  = lffu_pkg::NARROW_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [7:0]                data_byte,
   input  logic                      end_of_stream,
   output lffu_pkg::result_pair_type results
);
   import lffu_pkg::*;

   localparam bit HAS_FIELDS = (WIDE_CHANNELS + NARROW_COUNT) > 0;
   localparam bit HAS_WIDE   = WIDE_CHANNELS > 0;
   localparam bit HAS_NARROW = NARROW_COUNT > 0;
   localparam logic [3:0] WIDE_LAST   = 4'(WIDE_CHANNELS - 1);
   localparam logic [3:0] NARROW_LAST = 4'(NARROW_COUNT - 1);

   logic [31:0] buffer_ff, buffer_in;
   logic [4:0]  held_ff, held_in;
   logic [3:0]  counter_ff, counter_in;
   logic        narrow_grp_ff, narrow_grp_in;
   logic        started_ff, started_in;

   logic        narrow;
   logic [4:0]  need;
   logic [31:0] merged;
   logic [4:0]  held_sum;
   logic        complete;
   logic [3:0]  last;
   logic        wrap;
   logic        to_narrow;
   logic        fend;
   result_type  field_res;
   result_type  trunc_res;
   logic        trunc;

   always_comb begin
      narrow    = narrow_grp_ff || !HAS_WIDE;
      need      = narrow ? NARROW_BITS : WIDE_BITS;
      merged    = buffer_ff | ({24'b0, data_byte} << held_ff);
      held_sum  = held_ff + BYTE_BITS;
      complete  = HAS_FIELDS && (held_sum >= need);
      last      = narrow ? NARROW_LAST : WIDE_LAST;
      wrap      = counter_ff >= last;
      to_narrow = !narrow && HAS_NARROW;
      fend      = wrap && !to_narrow;

      field_res.field_value   = narrow ? {{16{merged[15]}}, merged[15:0]}
                                       : {merged[19:0], {WIDE_SHIFT{1'b0}}};
      field_res.channel_index = counter_ff;
      field_res.is_wide       = !narrow;
      field_res.frame_end     = fend;
      field_res.truncated     = 1'b0;

      trunc_res = '0;
      trunc_res.truncated = 1'b1;

      buffer_in     = buffer_ff;
      held_in       = held_ff;
      counter_in    = counter_ff;
      narrow_grp_in = narrow_grp_ff;
      started_in    = started_ff;

      if (HAS_FIELDS) begin
         if (complete) begin
            buffer_in  = merged >> need;
            held_in    = held_sum - need;
            started_in = !fend;
            if (wrap) begin
               counter_in    = 4'd0;
               narrow_grp_in = to_narrow;
            end else begin
               counter_in = counter_ff + 4'd1;
            end
         end else begin
            buffer_in = merged;
            held_in   = held_sum;
         end
      end

      trunc = end_of_stream && started_in;

      if (end_of_stream) begin
         buffer_in     = '0;
         held_in       = '0;
         counter_in    = '0;
         narrow_grp_in = 1'b0;
         started_in    = 1'b0;
      end

      results = '0;
      if (fire) begin
         if (complete) begin
            results.first_valid  = 1'b1;
            results.first        = field_res;
            results.second_valid = trunc;
            results.second       = trunc_res;
         end else begin
            results.first_valid = trunc;
            results.first       = trunc_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff     <= '0;
         held_ff       <= '0;
         counter_ff    <= '0;
         narrow_grp_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else if (fire) begin
         buffer_ff     <= buffer_in;
         held_ff       <= held_in;
         counter_ff    <= counter_in;
         narrow_grp_ff <= narrow_grp_in;
         started_ff    <= started_in;
      end
   end

endmodule

// File: rtl/core/lffu_result_fifo.sv
// Small result queue taking up to two results per cycle, one out per cycle while out_ready is high.
module lffu_result_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  lffu_pkg::result_pair_type wr,
   output logic                      room,
   output logic                      out_valid,
   input  logic                      out_ready,
   output lffu_pkg::result_type      out_data
);
   import lffu_pkg::*;

   result_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;
   logic [QUEUE_CNT_W-1:0] pushes;
   logic                   pop;

   always_comb begin
      out_valid = count_ff != '0;
      out_data  = entries_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      room      = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
      wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);
      pushes    = QUEUE_CNT_W'(wr.first_valid) + QUEUE_CNT_W'(wr.second_valid);
      count_in  = count_ff + pushes - QUEUE_CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(pushes);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.first_valid) begin
         entries_ff[wr_ptr_ff] <= wr.first;
      end
      if (wr.second_valid) begin
         entries_ff[wr_next] <= wr.second;
      end
   end

endmodule

// File: rtl/core/lsb_first_frame_field_unpacker.sv
// Unpacks LSB-first bit-continuous frames of wide (20-bit) and narrow
// (16-bit) signed fields from a byte stream. A byte is taken every cycle
// while the result queue has room; each byte yields zero or one field
// beat, plus a truncation beat when it ends the stream after a field of
// an unfinished frame. A four-entry result queue decouples the sides;
// req_ready falls only while that queue lacks room for two results, which
// happens only after rsp has been stalled.
`include "lsb_first_frame_field_unpacker_assert.svh"

module lsb_first_frame_field_unpacker #(
   parameter int WIDE_CHANNELS = lffu_pkg::WIDE_CHANNELS_DEFAULT,
   parameter int NARROW_COUNT  = lffu_pkg::NARROW_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_field_value,
   output logic [3:0]         rsp_channel_index,
   output logic               rsp_is_wide,
   output logic               rsp_frame_end,
   output logic               rsp_truncated
);
   import lffu_pkg::*;

   localparam logic [3:0] WIDE_LAST   = 4'(WIDE_CHANNELS - 1);
   localparam logic [3:0] NARROW_LAST = 4'(NARROW_COUNT - 1);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_eos_ff;
   logic            room;
   logic            proc_fire;
   result_pair_type pair;
   result_type      head;
   logic            wide_end;
   logic            narrow_end;
   logic            trunc_beat;
   logic            trunc_clean;

   assign proc_fire = in_valid_ff && room;
   assign req_ready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   lffu_core #(
      .WIDE_CHANNELS (WIDE_CHANNELS),
      .NARROW_COUNT  (NARROW_COUNT)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (proc_fire),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .results       (pair)
   );

   lffu_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (pair),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_field_value   = head.field_value;
   assign rsp_channel_index = head.channel_index;
   assign rsp_is_wide       = head.is_wide;
   assign rsp_frame_end     = head.frame_end;
   assign rsp_truncated     = head.truncated;

   assign wide_end    = rsp_valid && rsp_frame_end && rsp_is_wide;
   assign narrow_end  = rsp_valid && rsp_frame_end && !rsp_is_wide && !rsp_truncated;
   assign trunc_beat  = rsp_valid && rsp_truncated;
   assign trunc_clean = (rsp_field_value == 32'sd0) && !rsp_is_wide && !rsp_frame_end;

   `LFFU_ASSERT(a_wide_end_index, clock, reset, wide_end |-> rsp_channel_index == WIDE_LAST)
   `LFFU_ASSERT(a_narrow_end_index, clock, reset, narrow_end |-> rsp_channel_index == NARROW_LAST)
   `LFFU_ASSERT(a_trunc_empty, clock, reset, trunc_beat |-> trunc_clean)
   `LFFU_ASSERT_NEVER(a_second_alone, clock, reset, pair.second_valid && !pair.first_valid)

endmodule
